>>> hdl/gcsa_pkg.sv
// ============================================================================
// gcsa_pkg: shared types and constants of the glyph cache with shelf atlas
// Sizes of the atlas, the key table and the page set, the request and
// result layouts, record format, table control bundles and the key hash.
// ============================================================================
package gcsa_pkg;

  localparam int ATLAS_SIZE    = 256;
  localparam int TABLE_ENTRIES = 256;   // power of two, probe index wraps
  localparam int MAX_PAGES     = 16;

  localparam int KEY_W  = 38;
  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int CUR_W  = $clog2(ATLAS_SIZE + 1);
  localparam int POS_W  = 8;
  localparam int PAGE_W = 4;
  localparam int GDIM_W = 10;           // request width/height
  localparam int DIM_W  = 9;            // stored width/height
  localparam int BEAR_W = 11;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_EXHAUSTED = 2'd2
  } gcsa_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_PLACE,
    ST_EMIT
  } gcsa_state_t;

  // request, last field in the low bits
  typedef struct packed {
    logic signed [BEAR_W-1:0] glyph_top;
    logic signed [BEAR_W-1:0] glyph_left;
    logic [GDIM_W-1:0]        glyph_height;
    logic [GDIM_W-1:0]        glyph_width;
    logic                     glyph_empty;
    logic                     hinted;
    logic [20:0]              code_point;
    logic [7:0]               pixel_size;
    logic [7:0]               face_index;
  } gcsa_req_t;

  localparam int REQ_W     = $bits(gcsa_req_t);
  localparam int IN_DATA_W = ((REQ_W + 7) / 8) * 8;

  // result, last field in the low bits
  typedef struct packed {
    gcsa_status_t             status;
    logic signed [BEAR_W-1:0] out_top;
    logic signed [BEAR_W-1:0] out_left;
    logic [DIM_W-1:0]         out_height;
    logic [DIM_W-1:0]         out_width;
    logic [POS_W-1:0]         pos_y;
    logic [POS_W-1:0]         pos_x;
    logic [PAGE_W-1:0]        page;
    logic                     was_hit;
    logic                     present;
  } gcsa_out_t;

  localparam int RES_W      = $bits(gcsa_out_t);
  localparam int OUT_DATA_W = ((RES_W + 7) / 8) * 8;

  // cached glyph record
  typedef struct packed {
    logic                     present;
    logic [PAGE_W-1:0]        page;
    logic [POS_W-1:0]         x;
    logic [POS_W-1:0]         y;
    logic [DIM_W-1:0]         w;
    logic [DIM_W-1:0]         h;
    logic signed [BEAR_W-1:0] left;
    logic signed [BEAR_W-1:0] top;
  } gcsa_rec_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
  } gcsa_tbl_ctl_t;

  typedef struct packed {
    logic vld;     // probed slot holds a key
    logic match;   // and it is the lookup key
  } gcsa_tbl_sts_t;

  typedef struct packed {
    logic [CUR_W-1:0] col;
    logic [CUR_W-1:0] base;
    logic [CUR_W-1:0] lim;
  } gcsa_cur_t;

  typedef struct packed {
    logic              ok;
    logic              exhausted;
    logic [PAGE_W-1:0] page;
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
  } gcsa_place_t;

  function automatic logic [KEY_W-1:0] req_key(gcsa_req_t r);
    return {r.hinted, r.code_point, r.pixel_size, r.face_index};
  endfunction

  // xor fold of the key down to a table index
  function automatic logic [IDX_W-1:0] key_hash(logic [KEY_W-1:0] k);
    logic [IDX_W-1:0] h;
    h = '0;
    for (int i = 0; i < KEY_W; i++) begin
      h[i % IDX_W] = h[i % IDX_W] ^ k[i];
    end
    return h;
  endfunction

endpackage

>>> hdl/gcsa_table.sv
// ============================================================================
// gcsa_table: key and record store with the probe comparator
// One read and one write port, registered read; valid bits per slot are
// cleared by reset. The comparator checks the probed key every cycle.
// ============================================================================
module gcsa_table (
  input  logic                       clk,
  input  logic                       rst_n,
  input  gcsa_pkg::gcsa_tbl_ctl_t    ctl,
  input  logic [gcsa_pkg::KEY_W-1:0] lookup_key,
  input  gcsa_pkg::gcsa_rec_t        wr_rec,
  output gcsa_pkg::gcsa_tbl_sts_t    sts,
  output gcsa_pkg::gcsa_rec_t        rd_rec
);
  import gcsa_pkg::*;

  logic [KEY_W-1:0]         key_mem [TABLE_ENTRIES];
  gcsa_rec_t                rec_mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [KEY_W-1:0]         key_rd_r;
  gcsa_rec_t                rec_rd_r;
  logic                     vld_rd_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      key_mem[ctl.wr_addr] <= lookup_key;
      rec_mem[ctl.wr_addr] <= wr_rec;
    end
    if (ctl.rd_en) begin
      key_rd_r <= key_mem[ctl.rd_addr];
      rec_rd_r <= rec_mem[ctl.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      vld_rd_r <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        valid_r[ctl.wr_addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        vld_rd_r <= valid_r[ctl.rd_addr];
      end
    end
  end

  assign sts.vld   = vld_rd_r;
  assign sts.match = vld_rd_r && (key_rd_r == lookup_key);
  assign rd_rec    = rec_rd_r;

endmodule

>>> hdl/gcsa_packer.sv
// ============================================================================
// gcsa_packer: shelf packing state and placement
// Holds page and cursors; one placement per go, with the retry on a fresh
// page when the current page has no room.
// ============================================================================
module gcsa_packer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        go,
  input  logic [gcsa_pkg::GDIM_W-1:0] w,
  input  logic [gcsa_pkg::GDIM_W-1:0] h,
  output gcsa_pkg::gcsa_place_t       res
);
  import gcsa_pkg::*;

  localparam int SUM_W = CUR_W + 2;
  localparam logic [SUM_W-1:0] ATLAS_L = SUM_W'(ATLAS_SIZE);

  typedef struct packed {
    logic             ok;
    logic [CUR_W-1:0] x;
    logic [CUR_W-1:0] y;
    gcsa_cur_t        cur_nxt;
  } try_t;

  function automatic try_t try_place(gcsa_cur_t c, logic [GDIM_W-1:0] gw,
                                     logic [GDIM_W-1:0] gh);
    try_t             t;
    logic [SUM_W-1:0] sum_bh;
    logic [SUM_W-1:0] sum_cw;
    logic [SUM_W-1:0] sum_lh;
    logic [SUM_W-1:0] sum_yh;
    logic [SUM_W-1:0] end_v;
    sum_bh = SUM_W'(c.base) + SUM_W'(gh);
    sum_cw = SUM_W'(c.col) + SUM_W'(gw);
    sum_lh = SUM_W'(c.lim) + SUM_W'(gh);
    t.ok   = 1'b1;
    t.x    = c.col;
    t.y    = c.base;
    end_v  = sum_cw;
    if (gw == '0 || SUM_W'(gw) > ATLAS_L || SUM_W'(gh) > ATLAS_L ||
        sum_bh > ATLAS_L) begin
      t.ok = 1'b0;
    end else if (sum_cw > ATLAS_L) begin
      if (sum_lh > ATLAS_L) begin
        t.ok = 1'b0;
      end else begin
        t.x   = '0;
        t.y   = c.lim;
        end_v = SUM_W'(gw);
      end
    end
    sum_yh         = SUM_W'(t.y) + SUM_W'(gh);
    t.cur_nxt.col  = end_v[CUR_W-1:0];
    t.cur_nxt.base = t.y;
    t.cur_nxt.lim  = (sum_yh > SUM_W'(c.lim)) ? sum_yh[CUR_W-1:0] : c.lim;
    return t;
  endfunction

  gcsa_cur_t         cur_r, cur_nxt;
  logic [PAGE_W-1:0] page_r, page_nxt;
  try_t              try_cur, try_fresh;
  logic              fresh_ok;

  assign try_cur   = try_place(cur_r, w, h);
  assign try_fresh = try_place('0, w, h);
  assign fresh_ok  = ((PAGE_W + 1)'(page_r) + (PAGE_W + 1)'(1)) <
                     (PAGE_W + 1)'(MAX_PAGES);

  always_comb begin
    cur_nxt       = cur_r;
    page_nxt      = page_r;
    res.ok        = 1'b0;
    res.exhausted = 1'b0;
    res.page      = page_r;
    res.x         = try_cur.x[POS_W-1:0];
    res.y         = try_cur.y[POS_W-1:0];
    if (try_cur.ok) begin
      res.ok  = 1'b1;
      cur_nxt = try_cur.cur_nxt;
    end else if (fresh_ok) begin
      page_nxt = page_r + PAGE_W'(1);
      res.page = page_nxt;
      res.x    = try_fresh.x[POS_W-1:0];
      res.y    = try_fresh.y[POS_W-1:0];
      if (try_fresh.ok) begin
        res.ok  = 1'b1;
        cur_nxt = try_fresh.cur_nxt;
      end else begin
        cur_nxt = '0;
      end
    end else begin
      res.exhausted = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r  <= '0;
      page_r <= '0;
    end else if (go) begin
      cur_r  <= cur_nxt;
      page_r <= page_nxt;
    end
  end

endmodule

>>> hdl/glyph_cache_shelf_atlas.sv
// ============================================================================
// glyph_cache_shelf_atlas: glyph cache with shelf-packed atlas pages
// Looks a glyph key up in a hashed table by linear probing; a missed glyph is
// shelf-packed, if not empty, on the current or a fresh page; cached if room.
// ============================================================================
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------
//  in_     | in  | in_tvalid/tready   | in_tdata: glyph request (88 bits)
//  out_    | out | out_tvalid/tready  | out_tdata: glyph record, status (64)
//
// Flow: one transaction is in flight at a time. The probe loop reads one
// table slot per cycle through the single read port, starting at the key
// hash and probing up to TABLE_ENTRIES slots; a hit goes straight to the
// result, a miss passes through the placement state first.
// Reset: synchronous, active low; clears the slot valid bits at once (no
// clearing pass), the packing cursors and the handshake state.
// Stalls: the result sits in an output register; a new request is taken
// while it waits, and only the final hand-over waits on out_tready.
// ============================================================================
module glyph_cache_shelf_atlas (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [7:0] face_index, [15:8] pixel_size, [36:16] code_point, [37] hinted,
  // [38] glyph_empty, [48:39] glyph_width, [58:49] glyph_height,
  // [69:59] glyph_left, [80:70] glyph_top, [87:81] zero
  input  logic [gcsa_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [0] present, [1] was_hit, [5:2] page, [13:6] pos_x, [21:14] pos_y,
  // [30:22] out_width, [39:31] out_height, [50:40] out_left,
  // [61:51] out_top, [63:62] status
  output logic [gcsa_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import gcsa_pkg::*;

  gcsa_state_t      state_r, state_nxt;
  gcsa_req_t        req_r;
  gcsa_req_t        in_req;
  logic [IDX_W-1:0] probe_idx_r, probe_idx_nxt;
  logic [IDX_W-1:0] probe_cnt_r, probe_cnt_nxt;
  logic             full_r, full_nxt;      // probe walked the whole table
  gcsa_out_t        res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  gcsa_out_t        out_data_r, out_data_nxt;

  gcsa_tbl_ctl_t    tbl_ctl;
  gcsa_tbl_sts_t    tbl_sts;
  gcsa_rec_t        rd_rec;
  gcsa_rec_t        rec_new;
  gcsa_place_t      pl_res;
  logic             place_go;
  logic             cache;
  gcsa_status_t     stat;
  logic             in_accept;

  assign in_req    = gcsa_req_t'(in_tdata[REQ_W-1:0]);
  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;

  gcsa_table u_table (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (tbl_ctl),
    .lookup_key (req_key(req_r)),
    .wr_rec     (rec_new),
    .sts        (tbl_sts),
    .rd_rec     (rd_rec)
  );

  gcsa_packer u_packer (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (place_go),
    .w     (req_r.glyph_width),
    .h     (req_r.glyph_height),
    .res   (pl_res)
  );

  always_comb begin
    state_nxt     = state_r;
    probe_idx_nxt = probe_idx_r;
    probe_cnt_nxt = probe_cnt_r;
    full_nxt      = full_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    tbl_ctl       = '0;
    place_go      = 1'b0;
    rec_new       = '0;
    cache         = 1'b1;
    stat          = STAT_OK;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        // first probe read goes out with the accept
        if (in_tvalid) begin
          tbl_ctl.rd_en   = 1'b1;
          tbl_ctl.rd_addr = key_hash(req_key(in_req));
          probe_idx_nxt   = key_hash(req_key(in_req));
          probe_cnt_nxt   = '0;
          state_nxt       = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (tbl_sts.match) begin
          res_nxt.present    = rd_rec.present;
          res_nxt.was_hit    = 1'b1;
          res_nxt.page       = rd_rec.page;
          res_nxt.pos_x      = rd_rec.x;
          res_nxt.pos_y      = rd_rec.y;
          res_nxt.out_width  = rd_rec.w;
          res_nxt.out_height = rd_rec.h;
          res_nxt.out_left   = rd_rec.left;
          res_nxt.out_top    = rd_rec.top;
          res_nxt.status     = STAT_OK;
          state_nxt          = ST_EMIT;
        end else if (!tbl_sts.vld) begin
          full_nxt  = 1'b0;               // free slot at probe_idx_r
          state_nxt = ST_PLACE;
        end else if (probe_cnt_r == IDX_W'(TABLE_ENTRIES - 1)) begin
          full_nxt  = 1'b1;
          state_nxt = ST_PLACE;
        end else begin
          tbl_ctl.rd_en   = 1'b1;
          tbl_ctl.rd_addr = probe_idx_r + IDX_W'(1);
          probe_idx_nxt   = probe_idx_r + IDX_W'(1);
          probe_cnt_nxt   = probe_cnt_r + IDX_W'(1);
        end
      end
      ST_PLACE: begin
        if (!req_r.glyph_empty) begin
          place_go = 1'b1;
          if (pl_res.exhausted) begin
            stat  = STAT_EXHAUSTED;     // nothing cached, packing unchanged
            cache = 1'b0;
          end else if (pl_res.ok) begin
            rec_new.present = 1'b1;
            rec_new.page    = pl_res.page;
            rec_new.x       = pl_res.x;
            rec_new.y       = pl_res.y;
            rec_new.w       = req_r.glyph_width[DIM_W-1:0];
            rec_new.h       = req_r.glyph_height[DIM_W-1:0];
            rec_new.left    = req_r.glyph_left;
            rec_new.top     = req_r.glyph_top;
          end
        end
        if (cache && full_r) begin
          stat = STAT_FULL;
        end
        tbl_ctl.wr_en      = cache && !full_r;
        tbl_ctl.wr_addr    = probe_idx_r;
        res_nxt.present    = rec_new.present;
        res_nxt.was_hit    = 1'b0;
        res_nxt.page       = rec_new.page;
        res_nxt.pos_x      = rec_new.x;
        res_nxt.pos_y      = rec_new.y;
        res_nxt.out_width  = rec_new.w;
        res_nxt.out_height = rec_new.h;
        res_nxt.out_left   = rec_new.left;
        res_nxt.out_top    = rec_new.top;
        res_nxt.status     = stat;
        state_nxt          = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      probe_idx_r <= '0;
      probe_cnt_r <= '0;
      full_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      probe_idx_r <= probe_idx_nxt;
      probe_cnt_r <= probe_cnt_nxt;
      full_r      <= full_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_r <= in_req;
    end
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_data_r);

endmodule

>>> hdl/gcsa_checker.sv
// ============================================================================
// gcsa_checker: port-level checks for the glyph cache
// Watches the result channel for holding under stall and for consistent
// record fields; attached to the top level by bind.
// ============================================================================
module gcsa_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [gcsa_pkg::OUT_DATA_W-1:0] out_tdata
);
  import gcsa_pkg::*;

  gcsa_out_t o;
  assign o = gcsa_out_t'(out_tdata[RES_W-1:0]);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !o.present |-> o.page == '0 && o.pos_x == '0 && o.pos_y == '0 &&
      o.out_width == '0 && o.out_height == '0 && o.out_left == '0 && o.out_top == '0)
    else $error("absent result carries placement data");

  a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && o.was_hit |-> o.status == STAT_OK)
    else $error("hit with error status");

  a_exhausted: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && o.status == STAT_EXHAUSTED |-> !o.present && !o.was_hit)
    else $error("exhausted result with placement or hit");

  a_no_status3: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && in_tvalid && in_tready |-> o.status != 2'd3)
    else $error("undefined status code");

endmodule

bind glyph_cache_shelf_atlas gcsa_checker u_gcsa_checker (.*);
